### src/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants of the key matrix debouncer
// Item layouts, request codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmd_pkg;

	// Default geometry of the key matrix
	localparam int ROW_COUNT_DEF = 5;
	localparam int COL_COUNT_DEF = 19;

	// Field widths of the items
	localparam int REQ_W   = 2;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 5;
	localparam int BITS_W  = 19;
	localparam int DEB_W   = 8;
	localparam int TOTAL_W = 7;

	// Reset value of the debounce count and of the countdown
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

	// Saturation point of the key total
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 7'd127;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_END_SCAN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ROW_W-1:0]  row_index;
		logic [COL_W-1:0]  col_index;
		logic [BITS_W-1:0] col_bits;
	} req_item_t;

	typedef struct packed {
		logic [BITS_W-1:0]  stable_row;
		logic               key_on;
		logic               settled;
		logic               committed;
		logic [TOTAL_W-1:0] pressed_count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic write_sample;
		logic reload_cnt;
		logic dec_cnt;
		logic load_read;
		logic walk_start;
		logic walk_step;
		logic load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             row_ok;
		logic             differs;
		logic             cnt_nz;
		logic             cnt_one;
		logic             walk_last;
		logic             out_free;
	} dp_status_t;

endpackage

### src/kmd_stream_if.sv
// ----------------------------------------------------------------------------
// kmd_stream_if: valid/ready channel
// Carries one item of type T from a source to a sink; an item moves at a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/kmd_ctrl.sv
// ----------------------------------------------------------------------------
// kmd_ctrl: sequencing controller of the key matrix debouncer
// Takes one item, decides the datapath actions from its status, walks the
// rows on a commit and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kmd_pkg::dp_status_t status,
	output kmd_pkg::ctl_cmd_t   cmd
);
	import kmd_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decide next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (status.req_type)
					REQ_SAMPLE: begin
						if (status.row_ok && status.differs) begin
							cmd.write_sample = 1'b1;
							cmd.reload_cnt   = 1'b1;
						end
					end
					REQ_END_SCAN: begin
						if (status.cnt_nz) begin
							cmd.dec_cnt = 1'b1;
							if (status.cnt_one) begin
								cmd.walk_start = 1'b1;
								state_d        = ST_WALK;
							end
						end
					end
					REQ_READ: begin
						cmd.load_read = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/kmd_datapath.sv
// ----------------------------------------------------------------------------
// kmd_datapath: row storage, countdown and result register
// Holds sample and stable rows, the debounce countdown and the key total,
// and copies and counts one row per cycle during a commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmd_datapath #(
	parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = kmd_pkg::COL_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kmd_pkg::req_item_t         item,
	input  logic                       cfg_valid,
	input  logic [kmd_pkg::DEB_W-1:0]  cfg_data,
	input  kmd_pkg::ctl_cmd_t          cmd,
	output kmd_pkg::dp_status_t        status,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output kmd_pkg::rsp_item_t         rsp_item
);
	import kmd_pkg::*;

	localparam int RowIdxW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int ColIdxW = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
	localparam int PopW    = $clog2(COL_COUNT + 1);

	typedef logic [COL_COUNT-1:0] row_bits_t;

	// Count the pressed keys of one row
	function automatic logic [PopW-1:0] ones(input row_bits_t v);
		logic [PopW-1:0] n;
		n = '0;
		for (int i = 0; i < COL_COUNT; i++) begin
			n = n + PopW'(v[i]);
		end
		return n;
	endfunction

	req_item_t          item_q;
	logic [DEB_W-1:0]   debounce_q;
	logic [DEB_W-1:0]   countdown_q;
	row_bits_t          sample_q [ROW_COUNT];
	row_bits_t          stable_q [ROW_COUNT];
	logic [TOTAL_W-1:0] key_total_q;
	logic [RowIdxW-1:0] walk_q;
	logic               commit_q;
	row_bits_t          rd_row_q;
	logic               rd_key_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic [31:0]        row_ext;
	logic [31:0]        col_ext;
	logic [31:0]        bits_ext;
	logic [31:0]        out_ext;
	logic               row_ok;
	logic               col_ok;
	logic [RowIdxW-1:0] row_sel;
	logic [ColIdxW-1:0] col_sel;
	row_bits_t          bits_in;
	logic [RowIdxW-1:0] smp_addr;
	row_bits_t          smp_rd;
	row_bits_t          stb_rd;
	logic [PopW-1:0]    pop;
	logic [7:0]         tot_sum;
	logic [TOTAL_W-1:0] tot_sat;
	logic [DEB_W-1:0]   reload;

	// Decode the held item
	assign row_ext  = 32'(item_q.row_index);
	assign col_ext  = 32'(item_q.col_index);
	assign bits_ext = 32'(item_q.col_bits);
	assign row_ok   = row_ext < 32'(ROW_COUNT);
	assign col_ok   = col_ext < 32'(COL_COUNT);
	assign row_sel  = row_ext[RowIdxW-1:0];
	assign col_sel  = col_ext[ColIdxW-1:0];
	assign bits_in  = bits_ext[COL_COUNT-1:0];

	// Read the row stores: the walk owns the sample port during a commit
	assign smp_addr = cmd.walk_step ? walk_q : row_sel;
	assign smp_rd   = sample_q[smp_addr];
	assign stb_rd   = stable_q[row_sel];

	// Accumulate the key total with saturation
	assign pop     = ones(smp_rd);
	assign tot_sum = 8'(key_total_q) + 8'(pop);
	assign tot_sat = (tot_sum > 8'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

	// A zero debounce count acts as one
	assign reload = (debounce_q == '0) ? DEB_W'(1) : debounce_q;

	// Report status
	always_comb begin
		status.req_type  = item_q.req_type;
		status.row_ok    = row_ok;
		status.differs   = smp_rd != bits_in;
		status.cnt_nz    = countdown_q != '0;
		status.cnt_one   = countdown_q == DEB_W'(1);
		status.walk_last = walk_q == RowIdxW'(ROW_COUNT - 1);
		status.out_free  = !rsp_valid_q || rsp_ready;
	end

	// Hold configuration, countdown, rows and key total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RESET;
			countdown_q <= DEBOUNCE_RESET;
			key_total_q <= '0;
			walk_q      <= '0;
			for (int r = 0; r < ROW_COUNT; r++) begin
				sample_q[r] <= '0;
				stable_q[r] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				debounce_q <= cfg_data;
			end
			if (cmd.reload_cnt) begin
				countdown_q <= reload;
			end else if (cmd.dec_cnt) begin
				countdown_q <= countdown_q - DEB_W'(1);
			end
			if (cmd.write_sample) begin
				sample_q[row_sel] <= bits_in;
			end
			if (cmd.walk_start) begin
				walk_q      <= '0;
				key_total_q <= '0;
			end else if (cmd.walk_step) begin
				stable_q[walk_q] <= smp_rd;
				key_total_q      <= tot_sat;
				walk_q           <= walk_q + RowIdxW'(1);
			end
		end
	end

	// Hold the item and the per-item results
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q   <= item;
			commit_q <= 1'b0;
			rd_row_q <= '0;
			rd_key_q <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				commit_q <= 1'b1;
			end
			if (cmd.load_read) begin
				rd_row_q <= row_ok ? stb_rd : '0;
				rd_key_q <= (row_ok && col_ok) ? stb_rd[col_sel] : 1'b0;
			end
		end
	end

	// Track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the result
	assign out_ext = 32'(rd_row_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.stable_row    <= out_ext[BITS_W-1:0];
			rsp_q.key_on        <= rd_key_q;
			rsp_q.settled       <= countdown_q == '0;
			rsp_q.committed     <= commit_q;
			rsp_q.pressed_count <= key_total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

### src/key_matrix_debounce.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce: keyboard matrix debouncer with one global countdown
// Sequence: an item is accepted in IDLE, acted on in EXEC and, on a commit, in
// WALK, which copies and counts one row per cycle; DONE then loads the result.
// A new item is taken only once the result sits in the output register, and
// DONE waits while the output register is full and not being read.
// Reset: arst_n clears all rows and the key total, sets count and countdown 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_debounce #(
	parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT = kmd_pkg::COL_COUNT_DEF
) (
	input logic      clk,
	input logic      arst_n,
	kmd_stream_if.sink   req,
	kmd_stream_if.source rsp,
	kmd_stream_if.sink   cfg
);
	import kmd_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Configuration writes land at once
	assign cfg.ready = 1'b1;

	kmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	kmd_datapath #(
		.ROW_COUNT (ROW_COUNT),
		.COL_COUNT (COL_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (req.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_item  (rsp.data)
	);

`ifndef SYNTHESIS
	// A commit always leaves the block settled
	a_commit_settled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.committed |-> rsp.data.settled)
		else $error("committed result without settled");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while busy");

	// The commit walk runs only while no item is taken
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> !req.ready)
		else $error("commit walk while ready");

	// A result is loaded only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten");
`endif

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for key_matrix_debounce
// Runs directed items at the field extremes and the corner cases, then random
// scan passes under several debounce counts. Each accepted item goes through
// a debounce predictor, and every result is compared with the oldest pending
// expectation. Both channels idle at random, and the result side also holds
// off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import kmd_pkg::*;

	localparam int ROWS    = ROW_COUNT_DEF;
	localparam int COLS    = COL_COUNT_DEF;
	localparam int MAX_GAP = 13;

	// Request code that the block leaves unused
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	kmd_stream_if #(.T(req_item_t))         req_if ();
	kmd_stream_if #(.T(rsp_item_t))         rsp_if ();
	kmd_stream_if #(.T(logic [DEB_W-1:0])) cfg_if ();

	key_matrix_debounce #(
		.ROW_COUNT(ROWS),
		.COL_COUNT(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// Predicted debouncer state
	logic [DEB_W-1:0]   deb_count;
	logic [DEB_W-1:0]   countdown;
	logic [BITS_W-1:0]  sample_rows [ROWS];
	logic [BITS_W-1:0]  stable_rows [ROWS];
	logic [TOTAL_W-1:0] key_total;

	// Keys physically held down, used to build realistic scan passes
	logic [BITS_W-1:0]  keys_down [ROWS];

	rsp_item_t expected_rsp [$];

	int  errors;
	int  items_sent;
	int  reads_sent;
	int  results_seen;
	int  commits_seen;
	int  cfg_writes;
	int  hold_off;
	bit  gapless;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin : run_limit
		#5_000_000;
		$display("key_matrix_debounce verification failed");
		$finish;
	end

	function automatic req_item_t make_item(input logic [REQ_W-1:0] kind, input int row,
			input int col, input logic [31:0] bits);
		req_item_t it;
		it.req_type  = kind;
		it.row_index = row[ROW_W-1:0];
		it.col_index = col[COL_W-1:0];
		it.col_bits  = bits[BITS_W-1:0];
		return it;
	endfunction

	// Advance the predicted state by one item and return its result
	function automatic rsp_item_t debounce_step(input req_item_t it);
		rsp_item_t res;
		int        total;
		res = '0;
		case (it.req_type)
			REQ_SAMPLE: begin
				if (it.row_index < ROWS && sample_rows[it.row_index] != it.col_bits) begin
					sample_rows[it.row_index] = it.col_bits;
					// a zero count behaves as one
					countdown = (deb_count == '0) ? DEB_W'(1) : deb_count;
				end
			end
			REQ_END_SCAN: begin
				if (countdown != '0) begin
					countdown = countdown - 1'b1;
					if (countdown == '0) begin
						total = 0;
						for (int r = 0; r < ROWS; r++) begin
							stable_rows[r] = sample_rows[r];
							total += $countones(sample_rows[r]);
						end
						key_total = (total > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total);
						res.committed = 1'b1;
					end
				end
			end
			REQ_READ: begin
				if (it.row_index < ROWS) begin
					res.stable_row = stable_rows[it.row_index];
					if (it.col_index < COLS)
						res.key_on = res.stable_row[it.col_index];
				end
			end
			default: begin
			end
		endcase
		res.settled       = (countdown == '0);
		res.pressed_count = key_total;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Offer one item after a random gap and record its expectation on accept
	task automatic send_item(input req_item_t item);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		do @(posedge clk); while (!req_if.ready);
		expected_rsp.push_back(debounce_step(item));
		items_sent++;
		if (item.req_type == REQ_READ)
			reads_sent++;
	endtask

	// Drop valid and wait until every expected result is back
	task automatic drain();
		req_if.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [DEB_W-1:0] value);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		deb_count = value;
		cfg_writes++;
	endtask

	// Result side: check each result, then draw the next stall
	initial begin : rsp_side
		int        stall;
		rsp_item_t want;
		rsp_item_t got;
		stall = 0;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				results_seen++;
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: result with no item pending, expected none, got %p",
						$time, got);
				end else begin
					want = expected_rsp.pop_front();
					if (want.committed)
						commits_seen++;
					check_field("stable_row", 32'(want.stable_row), 32'(got.stable_row));
					check_field("key_on", 32'(want.key_on), 32'(got.key_on));
					check_field("settled", 32'(want.settled), 32'(got.settled));
					check_field("committed", 32'(want.committed), 32'(got.committed));
					check_field("pressed_count", 32'(want.pressed_count),
						32'(got.pressed_count));
				end
				stall = gapless ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_off > 0) begin
				hold_off--;
				rsp_if.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Field extremes, ignored rows and columns, spare code, reset count of five
	task automatic test_directed();
		send_item(make_item(REQ_READ, 0, 0, 0));
		send_item(make_item(REQ_SPARE, 7, 31, 32'h7FFFF));
		send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		send_item(make_item(REQ_SAMPLE, 0, 0, 32'h7FFFF));
		send_item(make_item(REQ_SAMPLE, 4, 31, 32'h55555));
		send_item(make_item(REQ_SAMPLE, 7, 0, 32'h2AAAA));
		send_item(make_item(REQ_SAMPLE, 5, 0, 32'h7FFFF));
		send_item(make_item(REQ_SAMPLE, 0, 0, 32'h7FFFF));
		repeat (5) send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		// end of scan once settled changes nothing
		send_item(make_item(REQ_END_SCAN, 7, 31, 32'h7FFFF));
		send_item(make_item(REQ_READ, 0, 18, 0));
		send_item(make_item(REQ_READ, 0, 19, 0));
		send_item(make_item(REQ_READ, 4, 31, 32'h7FFFF));
		send_item(make_item(REQ_READ, 4, 0, 0));
		send_item(make_item(REQ_READ, 4, 1, 0));
		send_item(make_item(REQ_READ, 6, 0, 0));
		send_item(make_item(REQ_READ, 7, 31, 0));
		send_item(make_item(REQ_SAMPLE, 0, 0, 0));
		send_item(make_item(REQ_READ, 0, 5, 0));
	endtask

	// Debounce counts of zero, 255 (the largest) and one
	task automatic test_debounce_extremes();
		write_debounce(8'd0);
		send_item(make_item(REQ_SAMPLE, 1, 0, 32'h40001));
		send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		send_item(make_item(REQ_READ, 1, 18, 0));

		write_debounce(8'd255);
		gapless = 1'b1;
		send_item(make_item(REQ_SAMPLE, 2, 0, 32'h7FFFF));
		repeat (255) send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		gapless = 1'b0;
		send_item(make_item(REQ_READ, 2, 18, 0));

		write_debounce(8'd1);
		send_item(make_item(REQ_SAMPLE, 3, 0, $urandom));
		send_item(make_item(REQ_END_SCAN, 0, 0, 0));
		send_item(make_item(REQ_READ, 3, $urandom_range(0, COLS - 1), 0));
	endtask

	// Random scan passes with occasional key changes, bounce and noise
	task automatic test_random_scans();
		int phase_end;
		for (int r = 0; r < ROWS; r++)
			keys_down[r] = sample_rows[r];
		for (int phase = 0; phase < 6; phase++) begin
			write_debounce(phase == 0 ? 8'd1 : DEB_W'($urandom_range(1, 6)));
			gapless   = (phase == 3);
			phase_end = items_sent + 100;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(make_item(REQ_W'($urandom), $urandom, $urandom, $urandom));
				end else begin
					for (int r = 0; r < ROWS; r++) begin
						if ($urandom_range(0, 19) == 0)
							keys_down[r] ^= BITS_W'(1) << $urandom_range(0, COLS - 1);
						else if ($urandom_range(0, 59) == 0)
							keys_down[r] = BITS_W'($urandom);
						// contact bounce ahead of the real sample
						if ($urandom_range(0, 29) == 0)
							send_item(make_item(REQ_SAMPLE, r, $urandom,
								32'(keys_down[r] ^ (BITS_W'(1) << $urandom_range(0, COLS - 1)))));
						send_item(make_item(REQ_SAMPLE, r, $urandom, 32'(keys_down[r])));
					end
					send_item(make_item(REQ_END_SCAN, $urandom, $urandom, $urandom));
					repeat ($urandom_range(0, 2))
						send_item(make_item(REQ_READ, $urandom_range(0, ROWS - 1),
							$urandom_range(0, COLS - 1), $urandom));
				end
			end
		end
		gapless = 1'b0;
	endtask

	// Hold off results while items keep coming so the block stalls its input
	task automatic test_output_stall();
		hold_off = 120;
		gapless  = 1'b1;
		repeat (30)
			send_item(make_item(REQ_W'($urandom_range(0, 2)), $urandom_range(0, ROWS - 1),
				$urandom_range(0, COLS - 1), $urandom));
		gapless = 1'b0;
	endtask

	initial begin : main_seq
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		errors       = 0;
		items_sent   = 0;
		reads_sent   = 0;
		results_seen = 0;
		commits_seen = 0;
		cfg_writes   = 0;
		hold_off     = 0;
		gapless      = 1'b0;
		deb_count    = DEBOUNCE_RESET;
		countdown    = DEBOUNCE_RESET;
		key_total    = '0;
		for (int r = 0; r < ROWS; r++) begin
			sample_rows[r] = '0;
			stable_rows[r] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_debounce_extremes();
		test_random_scans();
		test_output_stall();
		drain();

		$display("Covered %0d items (%0d reads), %0d results, %0d commits, %0d count writes.",
			items_sent, reads_sent, results_seen, commits_seen, cfg_writes);
		if (errors == 0)
			$display("key_matrix_debounce verification clean");
		else
			$display("key_matrix_debounce verification failed");
		$finish;
	end

endmodule

### files.f
src/kmd_pkg.sv
src/kmd_stream_if.sv
src/kmd_ctrl.sv
src/kmd_datapath.sv
src/key_matrix_debounce.sv
verif/tb.sv
